>>> rtl/core/bpe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpe_pkg: shared types and constants of the token encoder
// Field widths, opcodes, status codes, command and table entry types, and the
// sequencer state type of the engine.
// ----------------------------------------------------------------------------
package bpe_pkg;

   localparam int OPCODE_W = 3;
   localparam int ID_W     = 32;
   localparam int TEXT_W   = 64;
   localparam int LEN_W    = 4;
   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 2;
   localparam int CAP_W    = 7;

   localparam int VOCAB_DEPTH_DEF = 256;
   localparam int TOKEN_BYTES_DEF = 8;
   localparam int MERGE_DEPTH_DEF = 256;
   localparam int TEXT_DEPTH_DEF  = 64;
   localparam int QUEUE_DEPTH     = 2;

   localparam logic [ID_W-1:0]  BYTE_SPAN = 32'd256;
   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   localparam logic [OPCODE_W-1:0] OP_ADD_TOKEN = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_ADD_MERGE = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_FINALIZE  = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_CLEAR     = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_TEXT_BYTE = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOROOM  = 2'd2;

   typedef enum logic [2:0] {
      CMD_TOKEN,
      CMD_MERGE,
      CMD_FINALIZE,
      CMD_CLEAR,
      CMD_BYTE,
      CMD_BAD
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type            kind;
      logic                    len_bad;
      logic [ID_W-1:0]         id;
      logic [TEXT_W-1:0]       text;
      logic [LEN_W-1:0]        len;
      logic [ID_W-1:0]         left;
      logic [ID_W-1:0]         right;
      logic [ID_W-1:0]         result;
      logic [BYTE_W-1:0]       tbyte;
      logic                    fin;
   } cmd_type;

   typedef struct packed {
      logic [TEXT_W-1:0] text;
      logic [LEN_W-1:0]  len;
      logic [ID_W-1:0]   id;
   } vocab_entry_type;

   typedef struct packed {
      logic [ID_W-1:0] left;
      logic [ID_W-1:0] right;
      logic [ID_W-1:0] result;
   } merge_entry_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_POST,
      S_DUP_RD,
      S_DUP_CHK,
      S_KN_RD,
      S_KN_CHK,
      S_WIN_RD,
      S_WIN_LD,
      S_VS_RD,
      S_VS_CHK,
      S_MR_RD,
      S_MR_LD,
      S_SC_RD,
      S_SC_CHK,
      S_SH_RD,
      S_SH_WR,
      S_EM_START,
      S_EM_RD,
      S_EM_OUT
   } eng_state_type;

endpackage
`default_nettype wire

>>> rtl/core/bpe_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpe_if: channel interfaces of the token encoder
// Request, response and register write channels, each with valid and ready.
// ----------------------------------------------------------------------------
interface bpe_req_if;
   logic                          valid;
   logic                          ready;
   logic [bpe_pkg::OPCODE_W-1:0]  opcode;
   logic [bpe_pkg::ID_W-1:0]      new_token_id;
   logic [bpe_pkg::TEXT_W-1:0]    token_text;
   logic [bpe_pkg::LEN_W-1:0]     token_length;
   logic [bpe_pkg::ID_W-1:0]      merge_left;
   logic [bpe_pkg::ID_W-1:0]      merge_right;
   logic [bpe_pkg::ID_W-1:0]      merge_result;
   logic [bpe_pkg::BYTE_W-1:0]    text_byte;
   logic                          final_byte;

   modport source (output valid, opcode, new_token_id, token_text, token_length,
                   merge_left, merge_right, merge_result, text_byte, final_byte,
                   input ready);
   modport sink (input valid, opcode, new_token_id, token_text, token_length,
                 merge_left, merge_right, merge_result, text_byte, final_byte,
                 output ready);
endinterface

interface bpe_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bpe_pkg::STATUS_W-1:0]  status;
   logic [bpe_pkg::ID_W-1:0]      token_id;
   logic                          last_result;

   modport source (output valid, status, token_id, last_result, input ready);
   modport sink (input valid, status, token_id, last_result, output ready);
endinterface

interface bpe_csr_if;
   logic                          valid;
   logic                          ready;
   logic [bpe_pkg::CAP_W-1:0]     data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/bpe_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpe_front: request classifier
// Decodes the opcode, checks the token length and masks unused token bytes.
// ----------------------------------------------------------------------------
module bpe_front #(
   parameter int TOKEN_BYTES = bpe_pkg::TOKEN_BYTES_DEF
) (
   bpe_req_if.sink              req,
   output logic                 push_valid,
   input  logic                 push_ready,
   output bpe_pkg::cmd_type     push_cmd
);

   logic [bpe_pkg::TEXT_W-1:0] text_m;

   always_comb begin
      text_m = req.token_text;
      for (int b = 0; b < bpe_pkg::TEXT_W / 8; b++) begin
         if (bpe_pkg::LEN_W'(b) >= req.token_length) begin
            text_m[8*b +: 8] = 8'h00;
         end
      end
   end

   always_comb begin
      push_cmd.len_bad = (req.token_length == '0) ||
                         (req.token_length > bpe_pkg::LEN_W'(TOKEN_BYTES));
      push_cmd.id      = req.new_token_id;
      push_cmd.text    = text_m;
      push_cmd.len     = req.token_length;
      push_cmd.left    = req.merge_left;
      push_cmd.right   = req.merge_right;
      push_cmd.result  = req.merge_result;
      push_cmd.tbyte   = req.text_byte;
      push_cmd.fin     = req.final_byte;
      case (req.opcode)
         bpe_pkg::OP_ADD_TOKEN: push_cmd.kind = bpe_pkg::CMD_TOKEN;
         bpe_pkg::OP_ADD_MERGE: push_cmd.kind = bpe_pkg::CMD_MERGE;
         bpe_pkg::OP_FINALIZE:  push_cmd.kind = bpe_pkg::CMD_FINALIZE;
         bpe_pkg::OP_CLEAR:     push_cmd.kind = bpe_pkg::CMD_CLEAR;
         bpe_pkg::OP_TEXT_BYTE: push_cmd.kind = bpe_pkg::CMD_BYTE;
         default:               push_cmd.kind = bpe_pkg::CMD_BAD;
      endcase
   end

   assign push_valid = req.valid;
   assign req.ready  = push_ready;

endmodule
`default_nettype wire

>>> rtl/core/bpe_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpe_queue: command queue
// Small FIFO of classified commands between the classifier and the engine.
// ----------------------------------------------------------------------------
module bpe_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  bpe_pkg::cmd_type  push_cmd,
   output logic              pop_valid,
   input  logic              pop_ready,
   output bpe_pkg::cmd_type  pop_cmd
);

   localparam int QA = (bpe_pkg::QUEUE_DEPTH > 1) ? $clog2(bpe_pkg::QUEUE_DEPTH) : 1;
   localparam int QC = $clog2(bpe_pkg::QUEUE_DEPTH + 1);

   bpe_pkg::cmd_type slot_ff [bpe_pkg::QUEUE_DEPTH];
   logic [QA-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QC-1:0] fill_ff, fill_in;
   logic          push, pop;

   assign push_ready = (fill_ff != QC'(bpe_pkg::QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QA'(bpe_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QA'(bpe_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

>>> rtl/core/bpe_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpe_engine: table and encode sequencer
// Owns the vocabulary, merge, text and id memories and runs one command at a
// time: table updates, longest-prefix match, merge passes and id emission.
// ----------------------------------------------------------------------------
module bpe_engine #(
   parameter int VOCAB_DEPTH = bpe_pkg::VOCAB_DEPTH_DEF,
   parameter int TOKEN_BYTES = bpe_pkg::TOKEN_BYTES_DEF,
   parameter int MERGE_DEPTH = bpe_pkg::MERGE_DEPTH_DEF,
   parameter int TEXT_DEPTH  = bpe_pkg::TEXT_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  bpe_pkg::cmd_type  pop_cmd,
   bpe_rsp_if.source         rsp,
   bpe_csr_if.sink           csr
);

   localparam int VA = (VOCAB_DEPTH > 1) ? $clog2(VOCAB_DEPTH) : 1;
   localparam int VC = $clog2(VOCAB_DEPTH + 1);
   localparam int MA = (MERGE_DEPTH > 1) ? $clog2(MERGE_DEPTH) : 1;
   localparam int MC = $clog2(MERGE_DEPTH + 1);
   localparam int TA = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
   localparam int TC = $clog2(TEXT_DEPTH + 1);
   localparam int KW = (TOKEN_BYTES > 1) ? $clog2(TOKEN_BYTES) : 1;
   localparam int IW = bpe_pkg::ID_W;

   // memories
   bpe_pkg::vocab_entry_type vocab_mem [VOCAB_DEPTH];
   bpe_pkg::merge_entry_type merge_mem [MERGE_DEPTH];
   logic [7:0]               text_mem  [TEXT_DEPTH];
   logic [IW-1:0]            work_mem  [TEXT_DEPTH];

   bpe_pkg::vocab_entry_type vocab_rd_ff;
   bpe_pkg::merge_entry_type merge_rd_ff;
   logic [7:0]               text_rd_ff;
   logic [IW-1:0]            work_rd_ff;

   logic                     vocab_we, merge_we, text_we, work_we;
   bpe_pkg::vocab_entry_type vocab_wdata;
   bpe_pkg::merge_entry_type merge_wdata;
   logic [TA-1:0]            text_waddr, text_raddr, work_waddr, work_raddr;
   logic [IW-1:0]            work_wdata;
   logic [TC:0]              text_rsum;

   // control state
   bpe_pkg::eng_state_type   state_ff, state_in;
   bpe_pkg::cmd_type         cmd_ff, cmd_in;
   logic [bpe_pkg::CAP_W-1:0] cap_ff;
   logic [VC-1:0]            vcount_ff, vcount_in, idx_ff, idx_in;
   logic [MC-1:0]            mcount_ff, mcount_in, rank_ff, rank_in;
   logic [IW-1:0]            largest_ff, largest_in, fb_ff, fb_in;
   logic [TC-1:0]            tc_ff, tc_in, pos_ff, pos_in, n_ff, n_in;
   logic [TC-1:0]            i_ff, i_in, j_ff, j_in;
   logic                     ovf_ff, ovf_in, fl_ff, fl_in, fr_ff, fr_in;
   logic [KW-1:0]            k_ff, k_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   // payload state
   logic [bpe_pkg::LEN_W-1:0] match_len_ff, match_len_in;
   logic [IW-1:0]            best_id_ff, best_id_in, prev_ff, prev_in;
   logic [7:0]               win_ff [TOKEN_BYTES];
   logic [7:0]               win_in [TOKEN_BYTES];
   bpe_pkg::merge_entry_type rule_ff, rule_in;
   logic [bpe_pkg::STATUS_W-1:0] pend_ff, pend_in;
   logic [bpe_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [IW-1:0]            rsp_id_ff, rsp_id_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic                     out_free, mism;
   logic [TC-1:0]            rest, pos_next, i_next;
   logic                     tc_room, ovf_next;

   assign out_free        = !rsp_valid_ff || rsp.ready;
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.token_id    = rsp_id_ff;
   assign rsp.last_result = rsp_last_ff;
   assign csr.ready       = 1'b1;
   assign pop_ready       = (state_ff == bpe_pkg::S_IDLE);

   assign rest      = tc_ff - pos_ff;
   assign i_next    = i_ff + TC'(1);
   assign tc_room   = (tc_ff < TC'(TEXT_DEPTH));
   assign text_rsum = {1'b0, pos_ff} + (TC + 1)'(k_ff);
   assign text_raddr = (text_rsum < (TC + 1)'(TEXT_DEPTH)) ? text_rsum[TA-1:0] : '0;
   assign work_raddr = (state_ff == bpe_pkg::S_SH_RD || state_ff == bpe_pkg::S_SH_WR) ?
                       j_ff[TA-1:0] : i_ff[TA-1:0];

   // byte compare of the fetched vocabulary entry against the text window
   always_comb begin
      mism = 1'b0;
      for (int kk = 0; kk < TOKEN_BYTES; kk++) begin
         if (bpe_pkg::LEN_W'(kk) < vocab_rd_ff.len &&
             vocab_rd_ff.text[8*kk +: 8] != win_ff[kk]) begin
            mism = 1'b1;
         end
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      vcount_in   = vcount_ff;
      idx_in      = idx_ff;
      mcount_in   = mcount_ff;
      rank_in     = rank_ff;
      largest_in  = largest_ff;
      fb_in       = fb_ff;
      tc_in       = tc_ff;
      pos_in      = pos_ff;
      n_in        = n_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      ovf_in      = ovf_ff;
      fl_in       = fl_ff;
      fr_in       = fr_ff;
      k_in        = k_ff;
      match_len_in = match_len_ff;
      best_id_in  = best_id_ff;
      prev_in     = prev_ff;
      win_in      = win_ff;
      rule_in     = rule_ff;
      pend_in     = pend_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_last_in   = rsp_last_ff;
      vocab_we    = 1'b0;
      vocab_wdata = '{text: cmd_ff.text, len: cmd_ff.len, id: cmd_ff.id};
      merge_we    = 1'b0;
      merge_wdata = '{left: cmd_ff.left, right: cmd_ff.right, result: cmd_ff.result};
      text_we     = 1'b0;
      text_waddr  = tc_ff[TA-1:0];
      work_we     = 1'b0;
      work_waddr  = n_ff[TA-1:0];
      work_wdata  = work_rd_ff;
      pos_next    = pos_ff;
      ovf_next    = ovf_ff;

      case (state_ff)
         bpe_pkg::S_IDLE: begin
            if (pop_valid) begin
               cmd_in = pop_cmd;
               idx_in = '0;
               fl_in  = 1'b0;
               fr_in  = 1'b0;
               case (pop_cmd.kind)
                  bpe_pkg::CMD_TOKEN: begin
                     if (pop_cmd.len_bad) begin
                        pend_in  = bpe_pkg::STATUS_INVALID;
                        state_in = bpe_pkg::S_POST;
                     end else begin
                        state_in = bpe_pkg::S_DUP_RD;
                     end
                  end
                  bpe_pkg::CMD_MERGE: state_in = bpe_pkg::S_KN_RD;
                  bpe_pkg::CMD_FINALIZE: begin
                     fb_in    = (largest_ff >= bpe_pkg::BYTE_SPAN) ?
                                largest_ff + IW'(1) : bpe_pkg::BYTE_SPAN;
                     pend_in  = bpe_pkg::STATUS_OK;
                     state_in = bpe_pkg::S_POST;
                  end
                  bpe_pkg::CMD_CLEAR: begin
                     vcount_in  = '0;
                     mcount_in  = '0;
                     largest_in = '0;
                     fb_in      = bpe_pkg::BYTE_SPAN;
                     tc_in      = '0;
                     ovf_in     = 1'b0;
                     pend_in    = bpe_pkg::STATUS_OK;
                     state_in   = bpe_pkg::S_POST;
                  end
                  bpe_pkg::CMD_BYTE: begin
                     // buffer the byte, or drop it and flag overflow
                     if (tc_room) begin
                        text_we = 1'b1;
                        tc_in   = tc_ff + TC'(1);
                     end else begin
                        ovf_next = 1'b1;
                     end
                     ovf_in = ovf_next;
                     if (pop_cmd.fin) begin
                        if (ovf_next) begin
                           tc_in    = '0;
                           ovf_in   = 1'b0;
                           pend_in  = bpe_pkg::STATUS_INVALID;
                           state_in = bpe_pkg::S_POST;
                        end else begin
                           pos_in   = '0;
                           n_in     = '0;
                           k_in     = '0;
                           state_in = bpe_pkg::S_WIN_RD;
                        end
                     end
                  end
                  default: begin
                     pend_in  = bpe_pkg::STATUS_INVALID;
                     state_in = bpe_pkg::S_POST;
                  end
               endcase
            end
         end

         bpe_pkg::S_POST: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_ff;
               rsp_id_in     = '0;
               rsp_last_in   = 1'b1;
               state_in      = bpe_pkg::S_IDLE;
            end
         end

         bpe_pkg::S_DUP_RD: begin
            if (idx_ff == vcount_ff) begin
               if (vcount_ff >= VC'(VOCAB_DEPTH)) begin
                  pend_in = bpe_pkg::STATUS_NOROOM;
               end else begin
                  vocab_we  = 1'b1;
                  vcount_in = vcount_ff + VC'(1);
                  if (cmd_ff.id > largest_ff) begin
                     largest_in = cmd_ff.id;
                  end
                  pend_in = bpe_pkg::STATUS_OK;
               end
               state_in = bpe_pkg::S_POST;
            end else begin
               state_in = bpe_pkg::S_DUP_CHK;
            end
         end

         bpe_pkg::S_DUP_CHK: begin
            if (vocab_rd_ff.id == cmd_ff.id) begin
               pend_in  = bpe_pkg::STATUS_INVALID;
               state_in = bpe_pkg::S_POST;
            end else begin
               idx_in   = idx_ff + VC'(1);
               state_in = bpe_pkg::S_DUP_RD;
            end
         end

         bpe_pkg::S_KN_RD: begin
            if (idx_ff == vcount_ff) begin
               if (!(fl_ff && fr_ff)) begin
                  pend_in = bpe_pkg::STATUS_INVALID;
               end else if (mcount_ff >= MC'(MERGE_DEPTH)) begin
                  pend_in = bpe_pkg::STATUS_NOROOM;
               end else begin
                  merge_we  = 1'b1;
                  mcount_in = mcount_ff + MC'(1);
                  if (cmd_ff.result > largest_ff) begin
                     largest_in = cmd_ff.result;
                  end
                  pend_in = bpe_pkg::STATUS_OK;
               end
               state_in = bpe_pkg::S_POST;
            end else begin
               state_in = bpe_pkg::S_KN_CHK;
            end
         end

         bpe_pkg::S_KN_CHK: begin
            fl_in    = fl_ff || (vocab_rd_ff.id == cmd_ff.left);
            fr_in    = fr_ff || (vocab_rd_ff.id == cmd_ff.right);
            idx_in   = idx_ff + VC'(1);
            state_in = bpe_pkg::S_KN_RD;
         end

         bpe_pkg::S_WIN_RD: state_in = bpe_pkg::S_WIN_LD;

         bpe_pkg::S_WIN_LD: begin
            win_in[k_ff] = text_rd_ff;
            if (k_ff == KW'(TOKEN_BYTES - 1)) begin
               idx_in       = '0;
               match_len_in = '0;
               state_in     = bpe_pkg::S_VS_RD;
            end else begin
               k_in     = k_ff + KW'(1);
               state_in = bpe_pkg::S_WIN_RD;
            end
         end

         bpe_pkg::S_VS_RD: begin
            if (idx_ff == vcount_ff) begin
               // longest match wins, else fall back to the byte id (fallback base plus byte)
               work_we = 1'b1;
               if (match_len_ff != '0) begin
                  work_wdata = best_id_ff;
                  pos_next   = pos_ff + TC'(match_len_ff);
               end else begin
                  work_wdata = fb_ff + IW'(win_ff[0]);
                  pos_next   = pos_ff + TC'(1);
               end
               pos_in = pos_next;
               n_in   = n_ff + TC'(1);
               if (pos_next >= tc_ff) begin
                  rank_in  = '0;
                  state_in = bpe_pkg::S_MR_RD;
               end else begin
                  k_in     = '0;
                  state_in = bpe_pkg::S_WIN_RD;
               end
            end else begin
               state_in = bpe_pkg::S_VS_CHK;
            end
         end

         bpe_pkg::S_VS_CHK: begin
            if (8'(vocab_rd_ff.len) <= 8'(rest) && vocab_rd_ff.len > match_len_ff && !mism) begin
               match_len_in = vocab_rd_ff.len;
               best_id_in   = vocab_rd_ff.id;
            end
            idx_in   = idx_ff + VC'(1);
            state_in = bpe_pkg::S_VS_RD;
         end

         bpe_pkg::S_MR_RD: begin
            if (rank_ff == mcount_ff) begin
               state_in = bpe_pkg::S_EM_START;
            end else begin
               state_in = bpe_pkg::S_MR_LD;
            end
         end

         bpe_pkg::S_MR_LD: begin
            rule_in  = merge_rd_ff;
            i_in     = '0;
            state_in = bpe_pkg::S_SC_RD;
         end

         bpe_pkg::S_SC_RD: begin
            if (i_ff == n_ff) begin
               rank_in  = rank_ff + MC'(1);
               state_in = bpe_pkg::S_MR_RD;
            end else begin
               state_in = bpe_pkg::S_SC_CHK;
            end
         end

         bpe_pkg::S_SC_CHK: begin
            if (i_ff != '0 && prev_ff == rule_ff.left && work_rd_ff == rule_ff.right) begin
               // replace the pair and close the gap behind it
               work_we    = 1'b1;
               work_waddr = TA'(i_ff - TC'(1));
               work_wdata = rule_ff.result;
               j_in       = i_next;
               state_in   = bpe_pkg::S_SH_RD;
            end else begin
               prev_in  = work_rd_ff;
               i_in     = i_next;
               state_in = bpe_pkg::S_SC_RD;
            end
         end

         bpe_pkg::S_SH_RD: begin
            if (j_ff == n_ff) begin
               n_in     = n_ff - TC'(1);
               i_in     = '0;
               state_in = bpe_pkg::S_SC_RD;
            end else begin
               state_in = bpe_pkg::S_SH_WR;
            end
         end

         bpe_pkg::S_SH_WR: begin
            work_we    = 1'b1;
            work_waddr = TA'(j_ff - TC'(1));
            work_wdata = work_rd_ff;
            j_in       = j_ff + TC'(1);
            state_in   = bpe_pkg::S_SH_RD;
         end

         bpe_pkg::S_EM_START: begin
            tc_in  = '0;
            ovf_in = 1'b0;
            if (8'(n_ff) > 8'(cap_ff)) begin
               pend_in  = bpe_pkg::STATUS_NOROOM;
               state_in = bpe_pkg::S_POST;
            end else begin
               i_in     = '0;
               state_in = bpe_pkg::S_EM_RD;
            end
         end

         bpe_pkg::S_EM_RD: state_in = bpe_pkg::S_EM_OUT;

         bpe_pkg::S_EM_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = bpe_pkg::STATUS_OK;
               rsp_id_in     = work_rd_ff;
               rsp_last_in   = (i_next == n_ff);
               if (i_next == n_ff) begin
                  state_in = bpe_pkg::S_IDLE;
               end else begin
                  i_in     = i_next;
                  state_in = bpe_pkg::S_EM_RD;
               end
            end
         end

         default: state_in = bpe_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bpe_pkg::S_IDLE;
         cap_ff       <= bpe_pkg::CAP_RESET;
         vcount_ff    <= '0;
         mcount_ff    <= '0;
         largest_ff   <= '0;
         fb_ff        <= bpe_pkg::BYTE_SPAN;
         tc_ff        <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr.valid) begin
            cap_ff <= csr.data;
         end
         vcount_ff    <= vcount_in;
         mcount_ff    <= mcount_in;
         largest_ff   <= largest_in;
         fb_ff        <= fb_in;
         tc_ff        <= tc_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      idx_ff        <= idx_in;
      rank_ff       <= rank_in;
      pos_ff        <= pos_in;
      n_ff          <= n_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      fl_ff         <= fl_in;
      fr_ff         <= fr_in;
      k_ff          <= k_in;
      match_len_ff  <= match_len_in;
      best_id_ff    <= best_id_in;
      prev_ff       <= prev_in;
      win_ff        <= win_in;
      rule_ff       <= rule_in;
      pend_ff       <= pend_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (vocab_we) begin
         vocab_mem[vcount_ff[VA-1:0]] <= vocab_wdata;
      end
      vocab_rd_ff <= vocab_mem[idx_ff[VA-1:0]];
   end

   always_ff @(posedge clock) begin
      if (merge_we) begin
         merge_mem[mcount_ff[MA-1:0]] <= merge_wdata;
      end
      merge_rd_ff <= merge_mem[rank_ff[MA-1:0]];
   end

   always_ff @(posedge clock) begin
      if (text_we) begin
         text_mem[text_waddr] <= pop_cmd.tbyte;
      end
      text_rd_ff <= text_mem[text_raddr];
   end

   always_ff @(posedge clock) begin
      if (work_we) begin
         work_mem[work_waddr] <= work_wdata;
      end
      work_rd_ff <= work_mem[work_raddr];
   end

endmodule
`default_nettype wire

>>> rtl/core/bpe_token_encoder_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpe_token_encoder_top: byte pair encoding tokenizer
// Loadable vocabulary and merge tables with a greedy longest-prefix encoder
// followed by rank-ordered pair merging.
// ----------------------------------------------------------------------------
//
//   Port     Dir   Moves per transfer
//   req_if   sink  one command: table op, finalize, clear or one text byte
//   rsp_if   src   one result: status, token id, last flag
//   csr_if   sink  output capacity (7 bits, reset 64)
//
// Table ops check ids by walking the single read port of the vocabulary memory.
// An encode loads a TOKEN_BYTES window and scans the vocabulary per matched
// position, then per merge rank scans the ids and shifts them after each merge,
// then emits the ids. Non-final text bytes are buffered or, when full, dropped.
// Synchronous reset clears counts, flags and state, but not the memories.
// A stalled response holds the engine while the two-entry queue fills.
//
module bpe_token_encoder_top #(
   parameter int VOCAB_DEPTH = bpe_pkg::VOCAB_DEPTH_DEF,
   parameter int TOKEN_BYTES = bpe_pkg::TOKEN_BYTES_DEF,
   parameter int MERGE_DEPTH = bpe_pkg::MERGE_DEPTH_DEF,
   parameter int TEXT_DEPTH  = bpe_pkg::TEXT_DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   bpe_req_if.sink   req_if,
   bpe_rsp_if.source rsp_if,
   bpe_csr_if.sink   csr_if
);

   // classified command between front and engine
   logic             push_valid, push_ready, pop_valid, pop_ready;
   bpe_pkg::cmd_type push_cmd, pop_cmd;

   // decode and check each request transfer
   bpe_front #(
      .TOKEN_BYTES (TOKEN_BYTES)
   ) u_front (
      .req        (req_if),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   // decouple intake from the long-running engine
   bpe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   // execute commands and drive the response register
   bpe_engine #(
      .VOCAB_DEPTH (VOCAB_DEPTH),
      .TOKEN_BYTES (TOKEN_BYTES),
      .MERGE_DEPTH (MERGE_DEPTH),
      .TEXT_DEPTH  (TEXT_DEPTH)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_cmd   (pop_cmd),
      .rsp       (rsp_if),
      .csr       (csr_if)
   );

endmodule
`default_nettype wire
